// ===== src/rdc_pkg.sv =====
// Shared types, constants and helpers for the radix digit converter.
package rdc_pkg;

   // Sizing
   localparam int VALUE_BITS  = 31;
   localparam int DIGIT_DEPTH = 32;
   localparam int RADIX_BITS  = 5;
   localparam int DIGIT_BITS  = 4;
   localparam int CHAR_BITS   = 7;

   // Long division works on this many dividend bits per cycle
   localparam int BITS_PER_STEP = 8;
   localparam int DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int DIV_WIDTH     = DIV_STEPS * BITS_PER_STEP;
   localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Digit stack addressing
   localparam int ADDR_W = $clog2(DIGIT_DEPTH);
   localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);

   // Radix limits and character mapping
   localparam logic [RADIX_BITS-1:0] RADIX_MIN     = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX     = RADIX_BITS'(16);
   localparam logic [DIGIT_BITS-1:0] DECIMAL_LIMIT = DIGIT_BITS'(10);
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0]  CHAR_A        = CHAR_BITS'(65);

   // Input word
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0] radix;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit_value;
      logic [CHAR_BITS-1:0]  digit_char;
      logic                  last_digit;
      logic                  bad_radix;
   } rsp_word_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_PUSH,
      ST_READ,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic push;
      logic pop;
      logic emit;
      logic emit_bad;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_bad;
      logic div_done;
      logic quot_zero;
      logic last_slot;
      logic stack_empty;
   } status_type;

   // ASCII code of a digit: '0'-'9', then 'A'-'F'
   function automatic logic [CHAR_BITS-1:0] char_of(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ch;
      if (d < DECIMAL_LIMIT) begin
         ch = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         ch = CHAR_A + CHAR_BITS'(d - DECIMAL_LIMIT);
      end
      return ch;
   endfunction

endpackage

// ===== src/rdc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module rdc_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rdc_ctrl.sv =====
// Controller state machine for the radix digit converter.
module rdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rdc_pkg::status_type   status,
   output rdc_pkg::cmd_type      cmd,
   output logic                  busy
);

   rdc_pkg::state_type state_ff;
   rdc_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdc_pkg::ST_IDLE: begin
            if (start && !status.req_bad) begin
               state_in = rdc_pkg::ST_DIV;
            end
         end
         rdc_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = rdc_pkg::ST_PUSH;
            end
         end
         rdc_pkg::ST_PUSH: begin
            // stop dividing once the quotient is gone or the stack fills
            if (status.quot_zero || status.last_slot) begin
               state_in = rdc_pkg::ST_READ;
            end else begin
               state_in = rdc_pkg::ST_DIV;
            end
         end
         rdc_pkg::ST_READ: begin
            state_in = rdc_pkg::ST_EMIT;
         end
         rdc_pkg::ST_EMIT: begin
            if (status.stack_empty) begin
               state_in = rdc_pkg::ST_IDLE;
            end else begin
               state_in = rdc_pkg::ST_READ;
            end
         end
         default: begin
            state_in = rdc_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      case (state_ff)
         rdc_pkg::ST_IDLE: begin
            cmd.load     = start;
            cmd.emit_bad = start && status.req_bad;
         end
         rdc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         rdc_pkg::ST_PUSH: begin
            cmd.push = 1'b1;
         end
         rdc_pkg::ST_READ: begin
            cmd.pop = 1'b1;
         end
         rdc_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != rdc_pkg::ST_IDLE);

endmodule

// ===== src/rdc_datapath.sv =====
// Datapath: radix divider, digit stack and result register.
module rdc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rdc_pkg::req_word_type req_word,
   input  rdc_pkg::cmd_type      cmd,
   output rdc_pkg::status_type   status,
   output logic                  rsp_strobe,
   output rdc_pkg::rsp_word_type rsp_word
);

   logic [rdc_pkg::DIV_WIDTH-1:0]  quot_ff, quot_in;
   logic [rdc_pkg::DIGIT_BITS-1:0] rem_ff, rem_in;
   logic [rdc_pkg::RADIX_BITS-1:0] radix_ff;
   logic [rdc_pkg::STEP_W-1:0]     step_ff;
   logic [rdc_pkg::CNT_W-1:0]      count_ff;
   logic [rdc_pkg::CNT_W-1:0]      count_dec;
   logic [rdc_pkg::DIGIT_BITS-1:0] stack_rd_data;
   logic                           rsp_strobe_ff;
   rdc_pkg::rsp_word_type          rsp_word_ff;
   rdc_pkg::rsp_word_type          rsp_word_in;

   // Radix check on the incoming word
   assign status.req_bad = !(req_word.radix inside {[rdc_pkg::RADIX_MIN:rdc_pkg::RADIX_MAX]});

   // Restoring long division, BITS_PER_STEP quotient bits per cycle
   always_comb begin
      logic [rdc_pkg::DIV_WIDTH-1:0]  q;
      logic [rdc_pkg::DIGIT_BITS-1:0] r;
      logic [rdc_pkg::RADIX_BITS-1:0] t;
      q = quot_ff;
      r = rem_ff;
      for (int i = 0; i < rdc_pkg::BITS_PER_STEP; i++) begin
         t = {r, q[rdc_pkg::DIV_WIDTH-1]};
         q = {q[rdc_pkg::DIV_WIDTH-2:0], 1'b0};
         if (t >= radix_ff) begin
            t    = t - radix_ff;
            q[0] = 1'b1;
         end
         r = t[rdc_pkg::DIGIT_BITS-1:0];
      end
      quot_in = q;
      rem_in  = r;
   end

   // Division registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff  <= rdc_pkg::DIV_WIDTH'(req_word.value);
         radix_ff <= req_word.radix;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end else if (cmd.push) begin
         rem_ff <= '0;
      end
   end

   // Division step counter
   always_ff @(posedge clock) begin
      if (reset || cmd.load || cmd.push) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + rdc_pkg::STEP_W'(1);
      end
   end

   // Stack fill count
   assign count_dec = count_ff - rdc_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + rdc_pkg::CNT_W'(1);
      end else if (cmd.pop) begin
         count_ff <= count_dec;
      end
   end

   assign status.div_done    = (step_ff == rdc_pkg::STEP_W'(rdc_pkg::DIV_STEPS - 1));
   assign status.quot_zero   = (quot_ff == '0);
   assign status.last_slot   = (count_ff == rdc_pkg::CNT_W'(rdc_pkg::DIGIT_DEPTH - 1));
   assign status.stack_empty = (count_ff == '0);

   // Digit stack
   rdc_ram #(
      .WIDTH (rdc_pkg::DIGIT_BITS),
      .DEPTH (rdc_pkg::DIGIT_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[rdc_pkg::ADDR_W-1:0]),
      .wr_data (rem_ff),
      .rd_en   (cmd.pop),
      .rd_addr (count_dec[rdc_pkg::ADDR_W-1:0]),
      .rd_data (stack_rd_data)
   );

   // Result word
   always_comb begin
      if (cmd.emit_bad) begin
         rsp_word_in.digit_value = '0;
         rsp_word_in.digit_char  = '0;
         rsp_word_in.last_digit  = 1'b1;
         rsp_word_in.bad_radix   = 1'b1;
      end else begin
         rsp_word_in.digit_value = stack_rd_data;
         rsp_word_in.digit_char  = rdc_pkg::char_of(stack_rd_data);
         rsp_word_in.last_digit  = status.stack_empty;
         rsp_word_in.bad_radix   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit || cmd.emit_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit || cmd.emit_bad) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== src/radix_digit_converter_unit.sv =====
// Radix digit converter: a value goes in, its digits come out most significant first.
// A word is taken when start is high and busy is low. Each digit appears on rsp_word for
// exactly one cycle with rsp_strobe high; the receiver must take it then, as the block does
// not wait. For a radix from 2 to 16 the divider produces each digit by four 8-bit
// long-division steps (at 31-bit values) plus the stack push, and each digit is then read
// back from the stack by a read state and an emit state, so busy stays high for the whole
// conversion (up to 31 binary digits). A zero value yields the single digit '0'. A radix
// outside 2..16 gives one result with bad_radix set, the cycle after the word is taken,
// and busy never rises.
module radix_digit_converter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rdc_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output rdc_pkg::rsp_word_type rsp_word
);

   rdc_pkg::cmd_type    cmd;
   rdc_pkg::status_type status;

   // Sequencer
   rdc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Divider, stack and result register
   rdc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== tb/radix_digit_converter_unit_test.sv =====
// Self-checking testbench for the radix digit converter unit.
`timescale 1ns / 1ps

module radix_digit_converter_unit_test;
   import rdc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 250;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_strobe;
   rsp_word_type rsp_word;

   req_word_type values_to_send[$];
   rsp_word_type expected_digits[$];
   int idle_percent = 0;
   int error_count = 0;
   int cycle_count = 0;

   radix_digit_converter_unit dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected digit words for one accepted conversion, most significant first
   function automatic void predict_digits(input req_word_type w);
      logic [VALUE_BITS-1:0] rest;
      logic [DIGIT_BITS-1:0] stack [DIGIT_DEPTH];
      int depth;
      rsp_word_type r;
      rest = w.value;
      depth = 0;
      r = '0;
      if (w.radix < RADIX_MIN || w.radix > RADIX_MAX) begin
         r.last_digit = 1'b1;
         r.bad_radix = 1'b1;
         expected_digits.push_back(r);
         return;
      end
      // zero still gives one '0' digit
      if (rest == '0) begin
         stack[0] = '0;
         depth = 1;
      end
      while (rest != '0 && depth < DIGIT_DEPTH) begin
         stack[depth] = DIGIT_BITS'(rest % w.radix);
         depth++;
         rest = rest / w.radix;
      end
      for (int k = depth - 1; k >= 0; k--) begin
         r.digit_value = stack[k];
         if (stack[k] < DECIMAL_LIMIT) begin
            r.digit_char = CHAR_ZERO + CHAR_BITS'(stack[k]);
         end else begin
            r.digit_char = CHAR_A + CHAR_BITS'(stack[k] - DECIMAL_LIMIT);
         end
         r.last_digit = (k == 0);
         r.bad_radix = 1'b0;
         expected_digits.push_back(r);
      end
   endfunction

   // Driver: predict on acceptance, then present the next word or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // hold the word until taken
      end else begin
         if (start) begin
            predict_digits(req_word);
         end
         if (values_to_send.size() != 0 && $urandom_range(99) >= idle_percent) begin
            start <= 1'b1;
            req_word <= values_to_send.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed word must match the oldest expectation
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected digit word: value %0d char %0d last %0b bad %0b",
                   rsp_word.digit_value, rsp_word.digit_char,
                   rsp_word.last_digit, rsp_word.bad_radix);
            error_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_word.digit_value !== want.digit_value) begin
               $error("digit_value: expected %0d, got %0d",
                      want.digit_value, rsp_word.digit_value);
               error_count++;
            end
            if (rsp_word.digit_char !== want.digit_char) begin
               $error("digit_char: expected %0d, got %0d",
                      want.digit_char, rsp_word.digit_char);
               error_count++;
            end
            if (rsp_word.last_digit !== want.last_digit) begin
               $error("last_digit: expected %0b, got %0b",
                      want.last_digit, rsp_word.last_digit);
               error_count++;
            end
            if (rsp_word.bad_radix !== want.bad_radix) begin
               $error("bad_radix: expected %0b, got %0b",
                      want.bad_radix, rsp_word.bad_radix);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[radix_digit_converter_unit] ERROR");
         $finish;
      end
   end

   task automatic queue_word(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] rx);
      req_word_type w;
      w.value = v;
      w.radix = rx;
      values_to_send.push_back(w);
   endtask

   // Random conversions: mostly legal radixes, a mix of value sizes
   task automatic queue_random(input int count);
      logic [VALUE_BITS-1:0] v;
      logic [RADIX_BITS-1:0] rx;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: v = '0;
            1, 2: v = VALUE_BITS'($urandom_range(255, 1));
            3: v = '1;
            4: v = VALUE_BITS'($urandom_range(65535, 1));
            default: v = VALUE_BITS'($urandom());
         endcase
         if ($urandom_range(19) == 0) begin
            rx = RADIX_BITS'($urandom_range(31));
         end else begin
            rx = RADIX_BITS'($urandom_range(RADIX_MAX, RADIX_MIN));
         end
         queue_word(v, rx);
      end
   endtask

   task automatic wait_sent();
      while (values_to_send.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: largest value in every legal radix
      for (int rx = RADIX_MIN; rx <= RADIX_MAX; rx++) begin
         queue_word('1, RADIX_BITS'(rx));
      end
      // zero value, smallest digits, letter digits
      queue_word('0, RADIX_BITS'(10));
      queue_word('0, RADIX_MIN);
      queue_word(VALUE_BITS'(1), RADIX_MAX);
      queue_word(VALUE_BITS'(15), RADIX_MAX);
      queue_word(VALUE_BITS'(32'h5555_5555), RADIX_MAX);
      // radixes out of range, back to back with legal words
      queue_word(VALUE_BITS'(123), RADIX_BITS'(0));
      queue_word('1, RADIX_BITS'(1));
      queue_word('0, RADIX_BITS'(17));
      queue_word('1, RADIX_BITS'(31));
      wait_sent();

      // random phases with different sender gaps
      idle_percent = 0;
      queue_random(110);
      wait_sent();
      idle_percent = 71;
      queue_random(110);
      wait_sent();
      idle_percent = 0;
      queue_random(100);
      wait_sent();
      idle_percent = 14;
      queue_random(110);
      wait_sent();

      // wait for the last word to be taken and all digits to arrive
      while (start || expected_digits.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[radix_digit_converter_unit] OK");
      end else begin
         $display("[radix_digit_converter_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== radix_digit_converter_unit.f =====
src/rdc_pkg.sv
src/rdc_ram.sv
src/rdc_ctrl.sv
src/rdc_datapath.sv
src/radix_digit_converter_unit.sv
tb/radix_digit_converter_unit_test.sv
